// File: design/roi_thresholded_weighted_centroid_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the centroid block
// Shared concurrent assertion forms, clocked on clk_i and idle in reset.
// ----------------------------------------------------------------------------
`ifndef ROI_THRESHOLDED_WEIGHTED_CENTROID_ASSERT_SVH
`define ROI_THRESHOLDED_WEIGHTED_CENTROID_ASSERT_SVH

// same-cycle implication
`define RTWC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RTWC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

// File: design/rtwc_pkg.sv
// ----------------------------------------------------------------------------
// rtwc_pkg
// Widths, register indexes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rtwc_pkg;

  localparam int MaxWidth  = 512;
  localparam int MaxHeight = 512;
  localparam int FracBits  = 8;

  localparam int ColW  = $clog2(MaxWidth);
  localparam int RowW  = $clog2(MaxHeight);
  localparam int PixW  = 8;
  localparam int SumW  = 27;
  localparam int MomW  = 36;
  localparam int CntW  = 19;
  localparam int OSumW = 26;
  localparam int CentW = 17;
  localparam int DimW  = 10;
  localparam int OffW  = 9;
  localparam int CfgDataW = 10;
  localparam int CfgIdxW  = 4;

  localparam int DivW     = MomW + FracBits;
  localparam int DivCntW  = $clog2(DivW);

  localparam int OutBits   = 2 * CentW + OSumW + CntW;
  localparam int OutTdataW = ((OutBits + 7) / 8) * 8;

  localparam logic [CfgIdxW-1:0] CfgImageWidth  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgImageHeight = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] CfgRoiEnable   = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] CfgRoiLeft     = CfgIdxW'(3);
  localparam logic [CfgIdxW-1:0] CfgRoiTop      = CfgIdxW'(4);
  localparam logic [CfgIdxW-1:0] CfgRoiWidth    = CfgIdxW'(5);
  localparam logic [CfgIdxW-1:0] CfgRoiHeight   = CfgIdxW'(6);
  localparam logic [CfgIdxW-1:0] CfgThreshold   = CfgIdxW'(7);

  typedef struct packed {
    logic pix_en;
    logic pix_last;
    logic div_start;
    logic out_load;
  } rtwc_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic out_free;
  } rtwc_sts_t;

endpackage

// File: design/roi_thresholded_weighted_centroid.sv
// ----------------------------------------------------------------------------
// roi_thresholded_weighted_centroid
// Intensity-weighted centroid of thresholded pixels inside a region of interest.
// ----------------------------------------------------------------------------
// Pixels are taken one per clock in raster order while a frame streams in;
// the block keeps its own column and row position. The pixel with tlast set
// ends the frame: input ready then drops while the controller launches the
// two bit-serial restoring dividers that form the column and row quotients in
// parallel, waits until it sees them finish and moves the result into the
// output register once that register is free, and the first pixel of the next
// frame is taken in the cycle after that hand-off.
// The output register holds the result until it is taken, so the next frame
// streams in while it waits; only the hand-off of the next result stalls
// behind an untaken one. The user must write registers only while no frame
// is in flight and no result is being computed; the block does not enforce it.
`timescale 1ns / 1ps

module roi_thresholded_weighted_centroid (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // config write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rtwc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rtwc_pkg::CfgDataW-1:0] cfg_data_i,
  // pixel stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [7:0] pixel_value
  input  logic                          s_axis_tlast,  // frame_last
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [16:0] centroid_col, [33:17] centroid_row, [59:34] intensity_sum,
  // [78:60] pixel_area, [79] zero
  output logic [rtwc_pkg::OutTdataW-1:0] m_axis_tdata,
  output logic                          m_axis_tuser   // centroid_valid
);
  import rtwc_pkg::*;

  rtwc_cmd_t cmd;
  rtwc_sts_t sts;

  assign cfg_ready_o = 1'b1;

  rtwc_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tready (s_axis_tready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  rtwc_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_valid_i & cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .pix_i         (s_axis_tdata[PixW-1:0]),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// File: design/rtwc_div.sv
// ----------------------------------------------------------------------------
// rtwc_div
// Restoring divider, one quotient bit per cycle; quotient saturates to CentW.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rtwc_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [rtwc_pkg::MomW-1:0] moment_i,
  input  logic [rtwc_pkg::SumW-1:0] divisor_i,
  output logic                      busy_o,
  output logic [rtwc_pkg::CentW-1:0] quot_o
);
  import rtwc_pkg::*;

  logic [DivW-1:0]    num_q, num_d;
  logic [SumW:0]      rem_q, rem_d;
  logic [SumW-1:0]    den_q;
  logic [DivCntW-1:0] cnt_q;
  logic               busy_q;

  logic [SumW:0]   rem_sh;
  logic [SumW+1:0] diff;
  logic            ge;

  always_comb begin
    rem_sh = {rem_q[SumW-1:0], num_q[DivW-1]};
    diff   = {1'b0, rem_sh} - {2'b00, den_q};
    ge     = ~diff[SumW+1];
    rem_d  = ge ? diff[SumW:0] : rem_sh;
    num_d  = {num_q[DivW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == DivCntW'(DivW - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= DivW'(moment_i) << FracBits;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (busy_q) begin
      num_q <= num_d;
      rem_q <= rem_d;
    end
  end

  assign busy_o = busy_q;
  assign quot_o = (|num_q[DivW-1:CentW]) ? {CentW{1'b1}} : num_q[CentW-1:0];

endmodule

// File: design/rtwc_ctrl.sv
// ----------------------------------------------------------------------------
// rtwc_ctrl
// Frame sequencer: pixel intake, divide launch and result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "roi_thresholded_weighted_centroid_assert.svh"

module rtwc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tlast,
  output logic                  s_axis_tready,
  input  rtwc_pkg::rtwc_sts_t   sts_i,
  output rtwc_pkg::rtwc_cmd_t   cmd_o
);
  import rtwc_pkg::*;

  localparam logic [1:0] StRun   = 2'd0;
  localparam logic [1:0] StStart = 2'd1;
  localparam logic [1:0] StDiv   = 2'd2;
  localparam logic [1:0] StLoad  = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d        = state_q;
    s_axis_tready  = (state_q == StRun);
    cmd_o          = '0;
    cmd_o.pix_en   = s_axis_tvalid & s_axis_tready;
    cmd_o.pix_last = s_axis_tlast;
    case (state_q)
      StRun: begin
        if (cmd_o.pix_en && s_axis_tlast) begin
          state_d = StStart;
        end
      end
      StStart: begin
        // accumulators now include the last pixel
        cmd_o.div_start = 1'b1;
        state_d         = StDiv;
      end
      StDiv: begin
        if (!sts_i.div_busy) begin
          state_d = StLoad;
        end
      end
      StLoad: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = StRun;
        end
      end
      default: begin
        state_d = StRun;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StRun;
    end else begin
      state_q <= state_d;
    end
  end

  `RTWC_ASSERT_NEXT(a_start_busy, cmd_o.div_start, sts_i.div_busy, "divider did not start")
  `RTWC_ASSERT_IMPL(a_busy_stall, sts_i.div_busy, !s_axis_tready, "pixel taken mid divide")
  `RTWC_ASSERT_IMPL(a_load_free, cmd_o.out_load, sts_i.out_free, "result overwritten")

endmodule

// File: design/rtwc_dp.sv
// ----------------------------------------------------------------------------
// rtwc_dp
// Config registers, raster counters, moment accumulators, dividers, output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "roi_thresholded_weighted_centroid_assert.svh"

module rtwc_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rtwc_pkg::rtwc_cmd_t           cmd_i,
  output rtwc_pkg::rtwc_sts_t           sts_o,
  input  logic                          cfg_we_i,
  input  logic [rtwc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rtwc_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic [rtwc_pkg::PixW-1:0]     pix_i,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [rtwc_pkg::OutTdataW-1:0] m_axis_tdata,
  output logic                          m_axis_tuser
);
  import rtwc_pkg::*;

  localparam int CmpW = DimW + 1;

  // configuration
  logic [DimW-1:0] img_w_q, img_h_q, roi_w_q, roi_h_q;
  logic [OffW-1:0] roi_left_q, roi_top_q;
  logic            roi_en_q;
  logic [PixW-1:0] thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q    <= DimW'(320);
      img_h_q    <= DimW'(240);
      roi_en_q   <= 1'b0;
      roi_left_q <= '0;
      roi_top_q  <= '0;
      roi_w_q    <= '0;
      roi_h_q    <= '0;
      thr_q      <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgImageWidth:  img_w_q    <= cfg_data_i[DimW-1:0];
        CfgImageHeight: img_h_q    <= cfg_data_i[DimW-1:0];
        CfgRoiEnable:   roi_en_q   <= cfg_data_i[0];
        CfgRoiLeft:     roi_left_q <= cfg_data_i[OffW-1:0];
        CfgRoiTop:      roi_top_q  <= cfg_data_i[OffW-1:0];
        CfgRoiWidth:    roi_w_q    <= cfg_data_i[DimW-1:0];
        CfgRoiHeight:   roi_h_q    <= cfg_data_i[DimW-1:0];
        CfgThreshold:   thr_q      <= cfg_data_i[PixW-1:0];
        default: ;
      endcase
    end
  end

  // region bounds, end clipped to the image
  logic [CmpW-1:0] x0, y0, x1, y1, x1_roi, y1_roi;

  always_comb begin
    x1_roi = CmpW'(roi_left_q) + CmpW'(roi_w_q);
    y1_roi = CmpW'(roi_top_q) + CmpW'(roi_h_q);
    if (roi_en_q) begin
      x0 = CmpW'(roi_left_q);
      y0 = CmpW'(roi_top_q);
      x1 = (x1_roi < CmpW'(img_w_q)) ? x1_roi : CmpW'(img_w_q);
      y1 = (y1_roi < CmpW'(img_h_q)) ? y1_roi : CmpW'(img_h_q);
    end else begin
      x0 = '0;
      y0 = '0;
      x1 = CmpW'(img_w_q);
      y1 = CmpW'(img_h_q);
    end
  end

  // raster position
  logic [ColW-1:0] col_q;
  logic [RowW-1:0] row_q;
  logic            col_wrap, row_wrap, hit;

  assign col_wrap = (CmpW'(col_q) + 1'b1 >= CmpW'(img_w_q)) ||
                    (col_q == ColW'(MaxWidth - 1));
  assign row_wrap = (CmpW'(row_q) + 1'b1 >= CmpW'(img_h_q)) ||
                    (row_q == RowW'(MaxHeight - 1));
  assign hit = (CmpW'(col_q) >= x0) && (CmpW'(col_q) < x1) &&
               (CmpW'(row_q) >= y0) && (CmpW'(row_q) < y1) && (pix_i > thr_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cmd_i.pix_en) begin
      if (cmd_i.pix_last) begin
        col_q <= '0;
        row_q <= '0;
      end else if (col_wrap) begin
        col_q <= '0;
        row_q <= row_wrap ? '0 : row_q + 1'b1;
      end else begin
        col_q <= col_q + 1'b1;
      end
    end
  end

  // accumulators, each saturating at its own width
  logic [SumW-1:0] wt_q;
  logic [MomW-1:0] cmom_q, rmom_q;
  logic [CntW-1:0] hits_q;

  logic [ColW+PixW-1:0] cprod;
  logic [RowW+PixW-1:0] rprod;
  logic [SumW:0]        wt_sum;
  logic [MomW:0]        cmom_sum, rmom_sum;

  always_comb begin
    cprod    = (ColW+PixW)'(col_q) * (ColW+PixW)'(pix_i);
    rprod    = (RowW+PixW)'(row_q) * (RowW+PixW)'(pix_i);
    wt_sum   = {1'b0, wt_q} + (SumW+1)'(pix_i);
    cmom_sum = {1'b0, cmom_q} + (MomW+1)'(cprod);
    rmom_sum = {1'b0, rmom_q} + (MomW+1)'(rprod);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wt_q   <= '0;
      cmom_q <= '0;
      rmom_q <= '0;
      hits_q <= '0;
    end else if (cmd_i.out_load) begin
      wt_q   <= '0;
      cmom_q <= '0;
      rmom_q <= '0;
      hits_q <= '0;
    end else if (cmd_i.pix_en && hit) begin
      wt_q   <= wt_sum[SumW] ? {SumW{1'b1}} : wt_sum[SumW-1:0];
      cmom_q <= cmom_sum[MomW] ? {MomW{1'b1}} : cmom_sum[MomW-1:0];
      rmom_q <= rmom_sum[MomW] ? {MomW{1'b1}} : rmom_sum[MomW-1:0];
      hits_q <= (&hits_q) ? hits_q : hits_q + 1'b1;
    end
  end

  // column and row quotients run side by side
  logic             cdiv_busy, rdiv_busy;
  logic [CentW-1:0] ccent, rcent;

  rtwc_div u_div_col (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_start),
    .moment_i  (cmom_q),
    .divisor_i (wt_q),
    .busy_o    (cdiv_busy),
    .quot_o    (ccent)
  );

  rtwc_div u_div_row (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_start),
    .moment_i  (rmom_q),
    .divisor_i (wt_q),
    .busy_o    (rdiv_busy),
    .quot_o    (rcent)
  );

  // output register
  logic             out_vld_q, out_flag_q;
  logic [CentW-1:0] out_col_q, out_row_q;
  logic [OSumW-1:0] out_sum_q;
  logic [CntW-1:0]  out_area_q;
  logic             nonempty;

  assign nonempty = (wt_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_flag_q <= nonempty;
      out_col_q  <= nonempty ? ccent : '0;
      out_row_q  <= nonempty ? rcent : '0;
      out_area_q <= nonempty ? hits_q : '0;
      if (!nonempty) begin
        out_sum_q <= '0;
      end else if (|wt_q[SumW-1:OSumW]) begin
        out_sum_q <= {OSumW{1'b1}};
      end else begin
        out_sum_q <= wt_q[OSumW-1:0];
      end
    end
  end

  assign m_axis_tvalid  = out_vld_q;
  assign m_axis_tuser   = out_flag_q;
  assign m_axis_tdata   = OutTdataW'({out_area_q, out_sum_q, out_row_q, out_col_q});
  assign sts_o.div_busy = cdiv_busy | rdiv_busy;
  assign sts_o.out_free = ~out_vld_q | m_axis_tready;

  `RTWC_ASSERT_NEXT(a_acc_clear, cmd_i.out_load, (wt_q == '0) && (hits_q == '0), "accumulators not cleared")
  `RTWC_ASSERT_IMPL(a_empty_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == '0, "empty frame result not zero")
  `RTWC_ASSERT_IMPL(a_valid_sum, m_axis_tvalid && m_axis_tuser, (out_sum_q != '0) && (out_area_q != '0), "valid centroid with empty sums")

endmodule

// File: test/centroid_checker.sv
// ----------------------------------------------------------------------------
// centroid_checker
// Watches the config, pixel and result channels of the centroid block, keeps
// its own copy of the registers and accumulators, predicts one centroid per
// frame end and compares each taken result field by field, oldest first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module centroid_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [rtwc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [rtwc_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                           pix_valid_i,
  input  logic                           pix_ready_i,
  input  logic [rtwc_pkg::PixW-1:0]      pix_data_i,   // [7:0] pixel_value
  input  logic                           pix_last_i,   // frame_last
  input  logic                           res_valid_i,
  input  logic                           res_ready_i,
  // [16:0] centroid_col, [33:17] centroid_row, [59:34] intensity_sum,
  // [78:60] pixel_area
  input  logic [rtwc_pkg::OutTdataW-1:0] res_data_i,
  input  logic                           res_user_i,   // centroid_valid
  output int                             results_pending_o,
  output int                             mismatches_o
);
  import rtwc_pkg::*;

  localparam longint unsigned SumLim  = (64'd1 << SumW) - 1;
  localparam longint unsigned MomLim  = (64'd1 << MomW) - 1;
  localparam longint unsigned CntLim  = (64'd1 << CntW) - 1;
  localparam longint unsigned OSumLim = (64'd1 << OSumW) - 1;
  localparam longint unsigned CentLim = (64'd1 << CentW) - 1;
  localparam int              SumLo   = 2 * CentW;
  localparam int              AreaLo  = SumLo + OSumW;
  localparam int              MaxReports = 10;

  typedef struct packed {
    logic             found;
    logic [CentW-1:0] col;
    logic [CentW-1:0] row;
    logic [OSumW-1:0] sum;
    logic [CntW-1:0]  area;
  } frame_result_t;

  // register copy
  logic [DimW-1:0] img_w, img_h, roi_w, roi_h;
  logic            roi_on;
  logic [OffW-1:0] roi_x, roi_y;
  logic [PixW-1:0] thr;

  // raster position and accumulators
  logic [ColW-1:0] col_pos;
  logic [RowW-1:0] row_pos;
  logic [SumW-1:0] weight_sum;
  logic [MomW-1:0] col_mom, row_mom;
  logic [CntW-1:0] hits;

  frame_result_t centroid_q[$];
  int            mismatches = 0;

  function automatic longint unsigned sat_add(longint unsigned a, longint unsigned b,
                                              longint unsigned lim);
    return (a + b > lim) ? lim : a + b;
  endfunction

  function automatic longint unsigned min_of(longint unsigned a, longint unsigned b);
    return (a < b) ? a : b;
  endfunction

  // moment * 2^FracBits / sum, truncated, clamped to the output width
  function automatic longint unsigned fixed_mean(longint unsigned moment,
                                                 longint unsigned sum);
    longint unsigned q;
    q = (moment << FracBits) / sum;
    return min_of(q, CentLim);
  endfunction

  task automatic clear_frame();
    col_pos    = '0;
    row_pos    = '0;
    weight_sum = '0;
    col_mom    = '0;
    row_mom    = '0;
    hits       = '0;
  endtask

  task automatic reset_model();
    img_w  = DimW'(320);
    img_h  = DimW'(240);
    roi_on = 1'b0;
    roi_x  = '0;
    roi_y  = '0;
    roi_w  = '0;
    roi_h  = '0;
    thr    = '0;
    clear_frame();
    centroid_q.delete();
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    case (idx)
      CfgImageWidth:  img_w  = val[DimW-1:0];
      CfgImageHeight: img_h  = val[DimW-1:0];
      CfgRoiEnable:   roi_on = val[0];
      CfgRoiLeft:     roi_x  = val[OffW-1:0];
      CfgRoiTop:      roi_y  = val[OffW-1:0];
      CfgRoiWidth:    roi_w  = val[DimW-1:0];
      CfgRoiHeight:   roi_h  = val[DimW-1:0];
      CfgThreshold:   thr    = val[PixW-1:0];
      default: ;
    endcase
  endtask

  task automatic accumulate_pixel(input logic [PixW-1:0] v, input logic is_last);
    longint unsigned x0, y0, x1, y1;
    frame_result_t   res;
    if (roi_on) begin
      x0 = 64'(roi_x);
      y0 = 64'(roi_y);
      x1 = min_of(64'(roi_x) + 64'(roi_w), 64'(img_w));
      y1 = min_of(64'(roi_y) + 64'(roi_h), 64'(img_h));
    end else begin
      x0 = 0;
      y0 = 0;
      x1 = 64'(img_w);
      y1 = 64'(img_h);
    end
    if (col_pos >= x0 && col_pos < x1 && row_pos >= y0 && row_pos < y1 && v > thr) begin
      weight_sum = SumW'(sat_add(64'(weight_sum), 64'(v), SumLim));
      col_mom    = MomW'(sat_add(64'(col_mom), 64'(col_pos) * 64'(v), MomLim));
      row_mom    = MomW'(sat_add(64'(row_mom), 64'(row_pos) * 64'(v), MomLim));
      hits       = CntW'(sat_add(64'(hits), 64'd1, CntLim));
    end
    // width or height of zero behaves like one
    if (64'(col_pos) + 1 >= img_w || 64'(col_pos) + 1 >= MaxWidth) begin
      col_pos = '0;
      if (64'(row_pos) + 1 >= img_h || 64'(row_pos) + 1 >= MaxHeight) begin
        row_pos = '0;
      end else begin
        row_pos = row_pos + 1'b1;
      end
    end else begin
      col_pos = col_pos + 1'b1;
    end
    if (is_last) begin
      res = '0;
      if (weight_sum != 0) begin
        res.found = 1'b1;
        res.col   = CentW'(fixed_mean(64'(col_mom), 64'(weight_sum)));
        res.row   = CentW'(fixed_mean(64'(row_mom), 64'(weight_sum)));
        res.sum   = OSumW'(min_of(64'(weight_sum), OSumLim));
        res.area  = hits;
      end
      centroid_q.push_back(res);
      clear_frame();
    end
  endtask

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= MaxReports) begin
        $display("centroid mismatch on %s: expected %0d, got %0d", name, want, got);
      end
    end
  endtask

  task automatic compare_result();
    frame_result_t want, got;
    got.found = res_user_i;
    got.col   = res_data_i[CentW-1:0];
    got.row   = res_data_i[SumLo-1:CentW];
    got.sum   = res_data_i[AreaLo-1:SumLo];
    got.area  = res_data_i[AreaLo+CntW-1:AreaLo];
    if (centroid_q.size() == 0) begin
      mismatches++;
      if (mismatches <= MaxReports) begin
        $display("centroid result with no request pending: col %0d row %0d",
                 got.col, got.row);
      end
    end else begin
      want = centroid_q.pop_front();
      check_field("centroid_valid", 64'(want.found), 64'(got.found));
      check_field("centroid_col", 64'(want.col), 64'(got.col));
      check_field("centroid_row", 64'(want.row), 64'(got.row));
      check_field("intensity_sum", 64'(want.sum), 64'(got.sum));
      check_field("pixel_area", 64'(want.area), 64'(got.area));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_model();
    end else begin
      if (res_valid_i && res_ready_i) compare_result();
      if (cfg_valid_i && cfg_ready_i) write_reg(cfg_index_i, cfg_data_i);
      if (pix_valid_i && pix_ready_i) accumulate_pixel(pix_data_i, pix_last_i);
    end
    results_pending_o <= centroid_q.size();
    mismatches_o      <= mismatches;
  end

endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus for the region-of-interest centroid block: directed frames for the
// empty frame, row wrap, clipped and empty regions, then random register
// settings and frames (full, cut short, run past their end, very wide or very
// tall) under four idling phases. The checker predicts and compares results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import rtwc_pkg::*;

  localparam int ResetCycles  = 8;
  localparam int SettleCycles = 60;
  localparam int CycleLimit   = 1_000_000;
  localparam int PhaseItems   = 48;
  localparam int LongExtra    = 8;
  localparam int FrameCap     = 32;
  localparam logic [CfgIdxW-1:0] CfgFirstUnused = CfgThreshold + 1'b1;
  localparam logic [CfgIdxW-1:0] CfgLastUnused  = {CfgIdxW{1'b1}};
  localparam logic [DimW-1:0]    DimAllOnes     = {DimW{1'b1}};

  typedef enum int {EpochSmall, EpochWide, EpochTall} epoch_kind_e;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_valid_i   = 1'b0;
  logic [CfgIdxW-1:0]    cfg_index_i   = '0;
  logic [CfgDataW-1:0]   cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic [7:0]            s_axis_tdata  = '0;
  logic                  s_axis_tlast  = 1'b0;
  logic                  m_axis_tready = 1'b0;
  logic                  cfg_ready_o;
  logic                  s_axis_tready;
  logic                  m_axis_tvalid;
  logic [OutTdataW-1:0]  m_axis_tdata;
  logic                  m_axis_tuser;

  int results_pending;
  int mismatches;
  int pixels_sent  = 0;
  int tx_gap_pct   = 0;
  int rx_stall_pct = 0;

  // register values the stimulus is shaped around
  logic [DimW-1:0] img_w  = DimW'(320);
  logic [DimW-1:0] img_h  = DimW'(240);
  logic            roi_on = 1'b0;
  logic [OffW-1:0] roi_x  = '0;
  logic [OffW-1:0] roi_y  = '0;
  logic [DimW-1:0] roi_w  = '0;
  logic [DimW-1:0] roi_h  = '0;
  logic [PixW-1:0] thr    = '0;

  roi_thresholded_weighted_centroid dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  centroid_checker checker_i (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_i       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .pix_valid_i       (s_axis_tvalid),
    .pix_ready_i       (s_axis_tready),
    .pix_data_i        (s_axis_tdata),
    .pix_last_i        (s_axis_tlast),
    .res_valid_i       (m_axis_tvalid),
    .res_ready_i       (m_axis_tready),
    .res_data_i        (m_axis_tdata),
    .res_user_i        (m_axis_tuser),
    .results_pending_o (results_pending),
    .mismatches_o      (mismatches)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("Regression FAIL");
    $finish;
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic apply_config(input bit poke_unused);
    write_reg(CfgImageWidth, img_w);
    write_reg(CfgImageHeight, img_h);
    write_reg(CfgRoiEnable, CfgDataW'(roi_on));
    write_reg(CfgRoiLeft, CfgDataW'(roi_x));
    write_reg(CfgRoiTop, CfgDataW'(roi_y));
    write_reg(CfgRoiWidth, roi_w);
    write_reg(CfgRoiHeight, roi_h);
    write_reg(CfgThreshold, CfgDataW'(thr));
    // indexes past the register list must be ignored
    if (poke_unused) write_reg(CfgIdxW'($urandom_range(CfgFirstUnused, CfgLastUnused)),
                               CfgDataW'($urandom()));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_pixel(input logic [PixW-1:0] v, input logic is_last);
    while ($urandom_range(99) < tx_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    s_axis_tlast  <= is_last;
    do @(posedge clk_i); while (!s_axis_tready);
    pixels_sent++;
  endtask

  function automatic logic [PixW-1:0] pick_pixel();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return thr;
      3:       return (thr == '1) ? thr : thr + 1'b1;
      default: return PixW'($urandom());
    endcase
  endfunction

  task automatic send_frame(input int len);
    for (int i = 0; i < len; i++) send_pixel(pick_pixel(), i == len - 1);
  endtask

  // block is idle once every result is back and the divider has had time
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (results_pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic int eff_dim(input logic [DimW-1:0] d, input int lim);
    if (d == 0) return 1;
    return (d > lim) ? lim : int'(d);
  endfunction

  task automatic pick_small_config();
    case ($urandom_range(9))
      0:       img_w = '0;
      1:       img_w = DimW'(1);
      default: img_w = DimW'($urandom_range(1, 8));
    endcase
    case ($urandom_range(9))
      0:       img_h = '0;
      1:       img_h = DimW'($urandom_range(7, DimAllOnes));
      default: img_h = DimW'($urandom_range(1, 6));
    endcase
    roi_on = 1'($urandom_range(1));
    roi_x  = ($urandom_range(3) == 0) ? OffW'($urandom()) : OffW'($urandom_range(0, img_w + 1));
    roi_y  = ($urandom_range(3) == 0) ? OffW'($urandom()) : OffW'($urandom_range(0, 7));
    roi_w  = ($urandom_range(3) == 0) ? DimW'($urandom()) : DimW'($urandom_range(0, img_w + 1));
    roi_h  = ($urandom_range(3) == 0) ? DimW'($urandom()) : DimW'($urandom_range(0, 7));
    case ($urandom_range(7))
      0:       thr = '0;
      1:       thr = '1;
      default: thr = PixW'($urandom());
    endcase
  endtask

  task automatic run_epoch(input epoch_kind_e kind);
    int full, len, frames, shape;
    pick_small_config();
    if (kind == EpochWide) begin
      case ($urandom_range(2))
        0:       img_w = DimW'(MaxWidth);
        1:       img_w = DimAllOnes;
        default: img_w = DimW'($urandom_range(MaxWidth / 2, DimAllOnes));
      endcase
      img_h = DimW'($urandom_range(0, 3));
      roi_x = OffW'($urandom_range(0, MaxWidth - 1));
      roi_w = DimW'($urandom());
      thr   = PixW'($urandom_range(0, 128));
    end else if (kind == EpochTall) begin
      img_w = DimW'($urandom_range(0, 1));
      case ($urandom_range(2))
        0:       img_h = DimW'(MaxHeight);
        1:       img_h = DimAllOnes;
        default: img_h = DimW'($urandom_range(MaxHeight / 2, DimAllOnes));
      endcase
      roi_y = OffW'($urandom_range(0, MaxHeight - 1));
      roi_h = DimW'($urandom());
      thr   = PixW'($urandom_range(0, 128));
    end
    apply_config($urandom_range(3) == 0);
    full   = eff_dim(img_w, MaxWidth) * eff_dim(img_h, MaxHeight);
    frames = (kind == EpochSmall) ? $urandom_range(1, 4) : 1;
    repeat (frames) begin
      shape = $urandom_range(9);
      if (kind != EpochSmall) begin
        // long enough to wrap the 512-entry column or row counter
        len = $urandom_range(MaxWidth + 1, MaxWidth + LongExtra);
      end else begin
        if (shape == 0) len = $urandom_range(1, full);
        else if (shape == 1) len = full + $urandom_range(1, full);
        else len = full;
        if (len > FrameCap) len = $urandom_range(1, FrameCap);
      end
      send_frame(len);
    end
    wait_idle();
  endtask

  initial begin
    int goal;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: empty frame, then extremes of the pixel value
    send_pixel('0, 1'b1);
    send_pixel('1, 1'b0);
    send_pixel(PixW'(1), 1'b0);
    send_pixel('0, 1'b0);
    send_pixel(PixW'(128), 1'b0);
    send_pixel(PixW'(254), 1'b1);
    wait_idle();

    // zero width acts as one column; rows wrap at the image height
    img_w = '0;
    img_h = DimW'(3);
    apply_config(1'b1);
    repeat (3) send_pixel('1, 1'b0);
    send_pixel('1, 1'b1);
    wait_idle();

    // region clipped at the bottom edge, threshold is strict
    img_w  = DimW'(4);
    img_h  = DimW'(3);
    roi_on = 1'b1;
    roi_x  = OffW'(1);
    roi_y  = OffW'(1);
    roi_w  = DimW'(2);
    roi_h  = DimW'(5);
    thr    = PixW'(100);
    apply_config(1'b0);
    for (int i = 0; i < 12; i++) begin
      case (i % 4)
        0:       send_pixel(PixW'(101), i == 11);
        1:       send_pixel(PixW'(100), i == 11);
        2:       send_pixel('1, i == 11);
        default: send_pixel('0, i == 11);
      endcase
    end
    wait_idle();

    // region starting past the right edge counts nothing
    roi_x = OffW'(5);
    roi_w = DimW'(4);
    apply_config(1'b0);
    repeat (2) send_pixel('1, 1'b0);
    send_pixel('1, 1'b1);
    wait_idle();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_gap_pct = 71; rx_stall_pct = 0;  end
        2: begin tx_gap_pct = 0;  rx_stall_pct = 71; end
        default: begin tx_gap_pct = 32; rx_stall_pct = 32; end
      endcase
      // one long frame wraps a counter at its maximum
      if (ph == 1) run_epoch(EpochWide);
      else if (ph == 3) run_epoch(EpochTall);
      goal = pixels_sent + PhaseItems;
      while (pixels_sent < goal) begin
        run_epoch(EpochSmall);
      end
    end

    wait_idle();
    if (mismatches == 0 && results_pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
